// ----- rtl/lss_pkg.sv -----
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the searchable lifo stack.
// ----------------------------------------------------------------------------
package lss_pkg;

	localparam int DEPTH_DEF    = 32;
	localparam int WORD_W       = 32;
	localparam int CAP_W        = 6;
	localparam int POS_W        = 6;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 2;
	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_SEARCH = 3'd3,
		CMD_DUMP   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK
	} state_t;

endpackage

// ----- rtl/lifo_stack_with_search.sv -----
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Lifo stack of signed words in a synchronous ram, with search and dump.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall, cmd and value) takes one command word
// at a time: in_stall is high from acceptance until the command's last
// result word has been loaded into the output register.
// Output channel (out_valid / out_stall, status, data, position, last) is
// one registered stage; it holds its word while out_stall is high, and a
// result loads only when that register is free or draining.
// Timing: acceptance issues the ram read of the top entry. Push, pop and
// peek give their one result from EXEC once the output register is free,
// and the next command is taken after it loads. Search and dump walk the
// ram one entry per cycle from the top while the output register is free:
// search stops at a match or the bottom entry, dump gives fill words; an
// empty stack gives one status word. The single read port sets the walk rate.
// Undefined commands give no result and are dropped at acceptance, so the
// next command can be taken on the following cycle.
// capacity (capacity_we / capacity_wdata) sets the overflow limit; 0 acts
// as 1 and values above DEPTH act as DEPTH.
// Reset clears the fill count (stack empty) and sets capacity to 32; the
// ram is not cleared and needs no clearing pass.
module lifo_stack_with_search #(
	parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                capacity_we,
	input  logic [lss_pkg::CAP_W-1:0]           capacity_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lss_pkg::CMD_W-1:0]           cmd,
	input  logic signed [lss_pkg::WORD_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lss_pkg::STATUS_W-1:0]        status,
	output logic signed [lss_pkg::WORD_W-1:0]   data,
	output logic [lss_pkg::POS_W-1:0]           position,
	output logic                                last
);
	import lss_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int EW = CAP_W + 1;

	// storage
	logic signed [WORD_W-1:0] mem [DEPTH];
	logic signed [WORD_W-1:0] rd_q;

	state_t                   state_q, state_d;
	cmd_t                     cmd_q;
	logic signed [WORD_W-1:0] value_q;
	logic [FW-1:0]            fill_q, fill_d;
	logic [AW-1:0]            idx_q, idx_d;
	logic [POS_W-1:0]         pos_q, pos_d;
	logic [CAP_W-1:0]         cap_q;

	logic                     out_valid_q;
	status_t                  status_q;
	logic signed [WORD_W-1:0] data_q;
	logic [POS_W-1:0]         position_q;
	logic                     last_q;

	logic                     accept;
	logic                     out_free;
	logic                     emit;
	status_t                  emit_status;
	logic signed [WORD_W-1:0] emit_data;
	logic [POS_W-1:0]         emit_pos;
	logic                     emit_last;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	logic [EW-1:0]            eff_cap;
	logic                     fill_zero;
	logic                     full;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign fill_zero = (fill_q == '0);

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = EW'(1);
		end else if ({1'b0, cap_q} > EW'(DEPTH)) begin
			eff_cap = EW'(DEPTH);
		end else begin
			eff_cap = {1'b0, cap_q};
		end
	end

	assign full = (EW'(fill_q) >= eff_cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (capacity_we) begin
			cap_q <= capacity_wdata;
		end
	end

	// ram, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[AW-1:0]] <= value_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(cmd);
			value_q <= value;
		end
		idx_q <= idx_d;
		pos_q <= pos_d;
	end

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		idx_d       = idx_q;
		pos_d       = pos_q;
		rd_en       = 1'b0;
		rd_addr     = AW'(fill_q - FW'(1));
		wr_en       = 1'b0;
		emit        = 1'b0;
		emit_status = STAT_OK;
		emit_data   = '0;
		emit_pos    = '0;
		emit_last   = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_en = !fill_zero;
					idx_d = AW'(fill_q - FW'(1));
					pos_d = '0;
					case (cmd_t'(cmd))
						CMD_PUSH, CMD_POP, CMD_PEEK: state_d = ST_EXEC;
						CMD_SEARCH, CMD_DUMP: begin
							state_d = fill_zero ? ST_EXEC : ST_WALK;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					case (cmd_q)
						CMD_PUSH: begin
							if (full) begin
								emit_status = STAT_OVERFLOW;
							end else begin
								wr_en  = 1'b1;
								fill_d = fill_q + FW'(1);
							end
						end
						CMD_POP: begin
							if (fill_zero) begin
								emit_status = STAT_EMPTY;
							end else begin
								fill_d = fill_q - FW'(1);
							end
						end
						CMD_PEEK: begin
							if (fill_zero) begin
								emit_status = STAT_EMPTY;
							end else begin
								emit_data = rd_q;
							end
						end
						CMD_SEARCH: emit_status = STAT_NOTFOUND;
						default:    emit_status = STAT_EMPTY;
					endcase
				end
			end
			ST_WALK: begin
				if (out_free) begin
					// rd_q holds entry idx_q, pos_q places from the top
					if (cmd_q == CMD_DUMP) begin
						emit      = 1'b1;
						emit_data = rd_q;
						emit_pos  = pos_q;
						emit_last = (idx_q == '0);
					end else if (rd_q == value_q) begin
						emit      = 1'b1;
						emit_data = rd_q;
						emit_pos  = pos_q;
					end else if (idx_q == '0) begin
						emit        = 1'b1;
						emit_status = STAT_NOTFOUND;
					end
					if (idx_q == '0 || (cmd_q != CMD_DUMP && rd_q == value_q)) begin
						state_d = ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q - AW'(1);
						idx_d   = idx_q - AW'(1);
						pos_d   = pos_q + POS_W'(1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q   <= emit_status;
			data_q     <= emit_data;
			position_q <= emit_pos;
			last_q     <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign position  = position_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		EW'(fill_q) <= EW'(DEPTH))
		else $error("fill count beyond depth");

	a_walk_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |->
		(EW'(pos_q) + EW'(idx_q) + EW'(1) == EW'(fill_q)))
		else $error("walk index and position out of step");

	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && state_q == ST_EXEC && cmd_q == CMD_PUSH && emit_status == STAT_OK)
		|=> (fill_q == $past(fill_q) + FW'(1)))
		else $error("push did not grow the stack");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("result loaded over a stalled word");
`endif

endmodule
